[rtl/tmb_pkg.sv]
// Shared constants, codes and control types for the tile map box collision block.
package tmb_pkg;

  // Map storage and geometry
  localparam int MAX_COLUMNS   = 64;
  localparam int MAX_ROWS      = 64;
  localparam int TILE_SIZE     = 64;
  localparam int BOX_SIZE      = 60;
  localparam int FRACTION_BITS = 8;

  localparam int MAP_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Fixed-point sizes; the tile size must be a power of two
  localparam int TILE_FX    = TILE_SIZE << FRACTION_BITS;
  localparam int BOX_FX     = BOX_SIZE << FRACTION_BITS;
  localparam int TILE_SHIFT = $clog2(TILE_FX);
  localparam int HALF_BOX   = BOX_FX / 2;
  localparam int HALF_TILE  = TILE_FX / 2;
  localparam int MIN_DIST   = HALF_BOX + HALF_TILE;

  // Field widths
  localparam int POS_W     = 24;
  localparam int CORNER_W  = POS_W + 1;
  localparam int TCOORD_W  = CORNER_W - TILE_SHIFT;
  localparam int DIFF_W    = POS_W + 3;
  localparam int TILE_IX_W = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int POS_MAX   = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN   = -(2 ** (POS_W - 1));

  // Corner sequence
  localparam int           CORNER_W_IX = 2;
  localparam logic [1:0]   LAST_CORNER = 2'd3;

  // Command codes
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS    = 1'b1;
  localparam logic [CFG_W-1:0]     COLUMNS_RESET   = 7'd64;
  localparam logic [CFG_W-1:0]     ROWS_RESET      = 7'd64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_SETTLE,
    ST_DEPTH,
    ST_MOVE,
    ST_DONE
  } tmb_state_t;

  // Controller to datapath
  typedef struct packed {
    logic                   in_ready;
    logic                   clear;
    logic                   load;
    logic                   write_tile;
    logic                   probe;
    logic                   depth;
    logic                   move;
    logic                   emit;
    logic [CORNER_W_IX-1:0] corner;
  } tmb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } tmb_status_t;

endpackage

[rtl/tmb_in_if.sv]
// Input channel: tile writes and box resolve requests.
interface tmb_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [tmb_pkg::TILE_IX_W-1:0]       tile_col;
  logic [tmb_pkg::TILE_IX_W-1:0]       tile_row;
  logic                                solid;
  logic signed [tmb_pkg::POS_W-1:0]    pos_x;
  logic signed [tmb_pkg::POS_W-1:0]    pos_y;

  modport source (output valid, command, tile_col, tile_row, solid, pos_x, pos_y,
                  input ready);
  modport sink (input valid, command, tile_col, tile_row, solid, pos_x, pos_y,
                output ready);
endinterface

[rtl/tmb_out_if.sv]
// Result channel: resolved position and flags.
interface tmb_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tmb_pkg::POS_W-1:0] new_pos_x;
  logic signed [tmb_pkg::POS_W-1:0] new_pos_y;
  logic                             hit;
  logic                             left_map;

  modport source (output valid, new_pos_x, new_pos_y, hit, left_map, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, hit, left_map, output ready);
endinterface

[rtl/tmb_cfg_if.sv]
// Configuration write channel: register index and data.
interface tmb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tmb_pkg::CFG_IDX_W-1:0]     index;
  logic [tmb_pkg::CFG_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/tmb_ram.sv]
// Generic single-port RAM with registered read.
module tmb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first port; read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/tmb_ctl.sv]
// Sequencer for clearing, tile writes and the four-corner resolve.
module tmb_ctl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  input  tmb_pkg::tmb_status_t status,
  output tmb_pkg::tmb_cmd_t    cmd
);

  tmb_pkg::tmb_state_t                   state_r, state_nxt;
  logic [tmb_pkg::CORNER_W_IX-1:0]       corner_r, corner_nxt;

  // State and corner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tmb_pkg::ST_CLEAR;
      corner_r <= '0;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt  = state_r;
    corner_nxt = corner_r;
    cmd        = '0;
    cmd.corner = corner_r;
    case (state_r)
      tmb_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_nxt = tmb_pkg::ST_IDLE;
        end
      end
      tmb_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          corner_nxt = '0;
          if (in_command == tmb_pkg::CMD_WRITE) begin
            cmd.write_tile = 1'b1;
            state_nxt      = tmb_pkg::ST_DONE;
          end else begin
            state_nxt = tmb_pkg::ST_PROBE;
          end
        end
      end
      tmb_pkg::ST_PROBE: begin
        // Issue one corner read per cycle
        cmd.probe  = 1'b1;
        corner_nxt = corner_r + 1'b1;
        if (corner_r == tmb_pkg::LAST_CORNER) begin
          state_nxt = tmb_pkg::ST_SETTLE;
        end
      end
      tmb_pkg::ST_SETTLE: begin
        // Wait for the last corner's read data
        state_nxt = tmb_pkg::ST_DEPTH;
      end
      tmb_pkg::ST_DEPTH: begin
        cmd.depth = 1'b1;
        state_nxt = tmb_pkg::ST_MOVE;
      end
      tmb_pkg::ST_MOVE: begin
        cmd.move   = 1'b1;
        corner_nxt = corner_r + 1'b1;
        if (corner_r == tmb_pkg::LAST_CORNER) begin
          state_nxt = tmb_pkg::ST_DONE;
        end else begin
          state_nxt = tmb_pkg::ST_DEPTH;
        end
      end
      tmb_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = tmb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tmb_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

[rtl/tmb_dp.sv]
// Datapath: map memory, configuration, corner lookup, push-out and result register.
module tmb_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tmb_pkg::tmb_cmd_t                   cmd,
  output tmb_pkg::tmb_status_t                status,
  input  logic [tmb_pkg::TILE_IX_W-1:0]       in_tile_col,
  input  logic [tmb_pkg::TILE_IX_W-1:0]       in_tile_row,
  input  logic                                in_solid,
  input  logic signed [tmb_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [tmb_pkg::POS_W-1:0]    in_pos_y,
  tmb_cfg_if.sink                             cfg_ch,
  tmb_out_if.source                           out_ch
);

  localparam int AW = tmb_pkg::ADDR_W;
  localparam int DW = tmb_pkg::DIFF_W;
  localparam int PW = tmb_pkg::POS_W;
  localparam int CW = tmb_pkg::CORNER_W;
  localparam int TW = tmb_pkg::TCOORD_W;

  // Configuration registers
  logic [tmb_pkg::CFG_W-1:0] map_columns_r, map_rows_r;

  // Working registers
  logic signed [PW-1:0] x0_r, y0_r, px_r, py_r, px_nxt, py_nxt;
  logic [3:0]           solid_r;
  logic                 left_r;
  logic                 rd_pend_r, rd_in_map_r;
  logic [1:0]           rd_corner_r;
  logic signed [DW-1:0] xd_r, yd_r;
  logic                 xneg_r, yneg_r;
  logic [AW-1:0]        clr_addr_r;

  // Result register
  logic                 out_valid_r;
  logic signed [PW-1:0] out_x_r, out_y_r;
  logic                 out_hit_r, out_left_r;

  // Memory port
  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_addr, wr_addr, probe_addr;
  logic          wr_in_range;

  // Corner lookup
  logic signed [CW-1:0]            cx, cy;
  logic signed [TW-1:0]            tcol, trow;
  logic [tmb_pkg::COL_W-1:0]       col_idx;
  logic [tmb_pkg::ROW_W-1:0]       row_idx;
  int                              cols_lim, rows_lim;
  logic                            in_map;

  // Overlap depths
  logic signed [DW-1:0] org_x, org_y, dx, dy, adx, ady, xd, yd;

  function automatic logic signed [PW-1:0] sat_pos(input logic signed [DW-1:0] v);
    logic signed [PW-1:0] r;
    if (v > DW'(tmb_pkg::POS_MAX)) begin
      r = PW'(tmb_pkg::POS_MAX);
    end else if (v < DW'(tmb_pkg::POS_MIN)) begin
      r = PW'(tmb_pkg::POS_MIN);
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

  // Map the selected corner of the original box to a tile
  always_comb begin
    cx = CW'(x0_r) + (cmd.corner[1] ? CW'(tmb_pkg::BOX_FX) : CW'(0));
    cy = CW'(y0_r) + (cmd.corner[0] ? CW'(tmb_pkg::BOX_FX) : CW'(0));
    tcol = cx[CW-1:tmb_pkg::TILE_SHIFT];
    trow = cy[CW-1:tmb_pkg::TILE_SHIFT];
    cols_lim = (int'(map_columns_r) > tmb_pkg::MAX_COLUMNS) ? tmb_pkg::MAX_COLUMNS
                                                             : int'(map_columns_r);
    rows_lim = (int'(map_rows_r) > tmb_pkg::MAX_ROWS) ? tmb_pkg::MAX_ROWS
                                                      : int'(map_rows_r);
    in_map = !tcol[TW-1] && !trow[TW-1] &&
             (int'(tcol) < cols_lim) && (int'(trow) < rows_lim);
    col_idx = tcol[tmb_pkg::COL_W-1:0];
    row_idx = trow[tmb_pkg::ROW_W-1:0];
    probe_addr = AW'(int'(row_idx) * tmb_pkg::MAX_COLUMNS + int'(col_idx));
  end

  // Select the memory access: clearing pass, tile write or corner read
  always_comb begin
    wr_in_range = (int'(in_tile_col) < tmb_pkg::MAX_COLUMNS) &&
                  (int'(in_tile_row) < tmb_pkg::MAX_ROWS);
    wr_addr = AW'(int'(in_tile_row) * tmb_pkg::MAX_COLUMNS + int'(in_tile_col));
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_addr  = clr_addr_r;
      ram_wdata = 1'b0;
    end else if (cmd.write_tile) begin
      ram_we    = wr_in_range;
      ram_addr  = wr_addr;
      ram_wdata = in_solid;
    end else begin
      ram_we    = 1'b0;
      ram_addr  = probe_addr;
      ram_wdata = 1'b0;
    end
  end

  tmb_ram #(
    .WIDTH (1),
    .DEPTH (tmb_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Signed distance of box centre to tile centre, then overlap depth
  always_comb begin
    org_x = DW'(int'(col_idx) * tmb_pkg::TILE_FX);
    org_y = DW'(int'(row_idx) * tmb_pkg::TILE_FX);
    dx  = DW'(px_r) + DW'(tmb_pkg::HALF_BOX - tmb_pkg::HALF_TILE) - org_x;
    dy  = DW'(py_r) + DW'(tmb_pkg::HALF_BOX - tmb_pkg::HALF_TILE) - org_y;
    adx = dx[DW-1] ? -dx : dx;
    ady = dy[DW-1] ? -dy : dy;
    xd  = DW'(tmb_pkg::MIN_DIST) - adx;
    yd  = DW'(tmb_pkg::MIN_DIST) - ady;
  end

  // Push along the axis of smaller overlap, ties to y
  always_comb begin
    px_nxt = px_r;
    py_nxt = py_r;
    if (cmd.load) begin
      px_nxt = in_pos_x;
      py_nxt = in_pos_y;
    end else if (cmd.move && solid_r[cmd.corner] && (xd_r > 0) && (yd_r > 0)) begin
      if (xd_r < yd_r) begin
        px_nxt = sat_pos(DW'(px_r) + (xneg_r ? -xd_r : xd_r));
      end else begin
        py_nxt = sat_pos(DW'(py_r) + (yneg_r ? -yd_r : yd_r));
      end
    end
  end

  // Control registers: clearing address, read tracking, result valid, configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r    <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      map_columns_r <= tmb_pkg::COLUMNS_RESET;
      map_rows_r    <= tmb_pkg::ROWS_RESET;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      rd_pend_r <= cmd.probe;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          tmb_pkg::CFG_MAP_COLUMNS: map_columns_r <= cfg_ch.data;
          tmb_pkg::CFG_MAP_ROWS:    map_rows_r    <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    rd_corner_r <= cmd.corner;
    rd_in_map_r <= in_map;
    if (cmd.load) begin
      x0_r    <= in_pos_x;
      y0_r    <= in_pos_y;
      solid_r <= '0;
      left_r  <= 1'b0;
    end else if (rd_pend_r) begin
      // Capture the corner read issued last cycle
      if (rd_in_map_r) begin
        solid_r[rd_corner_r] <= ram_rdata;
      end else begin
        left_r <= 1'b1;
      end
    end
    if (cmd.depth) begin
      xd_r   <= xd;
      yd_r   <= yd;
      xneg_r <= dx[DW-1];
      yneg_r <= dy[DW-1];
    end
    if (cmd.emit) begin
      out_x_r    <= px_r;
      out_y_r    <= py_r;
      out_hit_r  <= |solid_r;
      out_left_r <= left_r;
    end
  end

  assign status.clear_last = (clr_addr_r == AW'(tmb_pkg::MAP_DEPTH - 1));
  assign status.out_free   = !out_valid_r || out_ch.ready;

  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.new_pos_x = out_x_r;
  assign out_ch.new_pos_y = out_y_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.left_map  = out_left_r;

endmodule

[rtl/tile_map_box_collision_top.sv]
// Top level of the tile map box collision block.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    command, tile_col, tile_row, solid, pos_x, pos_y
//   out_ch   out  valid / ready    new_pos_x, new_pos_y, hit, left_map
//   cfg_ch   in   valid / ready    index (0 map_columns, 1 map_rows), data
//
// A resolve makes four corner reads through the single map memory port, waits in a
// settle state for the last read data, runs a depth and a push step for each of the
// four corners in order, then loads the result. A tile write goes straight to the
// result load. in_ch is ready again in the same cycle that the result becomes
// valid; one transaction is in work at a time. After reset a clearing pass zeroes
// all 4096 map entries; in_ch is not ready meanwhile, while cfg_ch is always ready.
// A stalled result holds in the output register; the next transaction is still
// taken and worked, then waits until the register is free.
module tile_map_box_collision_top (
  input  logic      clk,
  input  logic      rst_n,
  tmb_in_if.sink    in_ch,
  tmb_out_if.source out_ch,
  tmb_cfg_if.sink   cfg_ch
);

  tmb_pkg::tmb_cmd_t    cmd;
  tmb_pkg::tmb_status_t status;

  assign in_ch.ready = cmd.in_ready;

  tmb_ctl u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .status     (status),
    .cmd        (cmd)
  );

  tmb_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_tile_col (in_ch.tile_col),
    .in_tile_row (in_ch.tile_row),
    .in_solid    (in_ch.solid),
    .in_pos_x    (in_ch.pos_x),
    .in_pos_y    (in_ch.pos_y),
    .cfg_ch      (cfg_ch),
    .out_ch      (out_ch)
  );

endmodule

[rtl/tmb_checker.sv]
// Port-level assertions for the tile map box collision top level, with bind.
module tmb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [tmb_pkg::POS_W-1:0] out_new_pos_x,
  input logic signed [tmb_pkg::POS_W-1:0] out_new_pos_y,
  input logic                             out_hit,
  input logic                             out_left_map
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_pos_x) &&
      $stable(out_new_pos_y) && $stable(out_hit) && $stable(out_left_map))
    else $error("stalled result changed");

  // Reset drops the result and starts the clearing pass
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or valid after reset");

  // One transaction in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // A new result only follows work, never an idle input side
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a transaction in work");

endmodule

bind tile_map_box_collision_top tmb_checker u_tmb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_new_pos_x (out_ch.new_pos_x),
  .out_new_pos_y (out_ch.new_pos_y),
  .out_hit       (out_ch.hit),
  .out_left_map  (out_ch.left_map)
);
